FILE: hw/rtl/aes_sbox_forward_defines.svh
// assertion macros for the aes s-box block
`ifndef AES_SBOX_FORWARD_DEFINES_SVH
`define AES_SBOX_FORWARD_DEFINES_SVH

// same-cycle implication, checked on every clock edge outside reset
`define ASF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every clock edge outside reset
`define ASF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/asf_pkg.sv
// shared types, constants and field arithmetic for the aes s-box pipeline
package asf_pkg;

    localparam int ROUNDS  = 6;
    localparam int LATENCY = ROUNDS + 1;

    localparam logic [7:0] POLY_LOW     = 8'h1b;
    localparam logic [7:0] AFFINE_CONST = 8'h63;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] x;
    } asf_stage_t;

    // product modulo x^8+x^4+x^3+x+1
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] sh;
        acc = 8'h00;
        sh  = a;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
            begin
                acc = acc ^ sh;
            end
            if (sh[7])
            begin
                sh = {sh[6:0], 1'b0} ^ POLY_LOW;
            end
            else
            begin
                sh = {sh[6:0], 1'b0};
            end
        end
        return acc;
    endfunction

    function automatic logic [7:0] gf_sq(input logic [7:0] a);
        return gf_mul(a, a);
    endfunction

    function automatic logic [7:0] affine(input logic [7:0] v);
        return v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]}
                 ^ {v[3:0], v[7:4]} ^ AFFINE_CONST;
    endfunction

endpackage

FILE: hw/rtl/asf_round.sv
// one square-and-multiply stage of the x^254 inversion chain
module asf_round
    import asf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  asf_stage_t in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output asf_stage_t out_data
);

    logic       valid_reg;
    asf_stage_t data_reg;
    asf_stage_t data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        data_next.x = in_data.x;
        data_next.r = gf_mul(gf_sq(in_data.r), in_data.x);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: hw/rtl/asf_affine.sv
// final square and affine map, doubles as the output register
module asf_affine
    import asf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  asf_stage_t in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    assign in_ready  = !valid_reg || out_ready;
    assign byte_next = affine(gf_sq(in_data.r));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= byte_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;

endmodule

FILE: hw/rtl/aes_sbox_forward.sv
// aes forward s-box, inversion by x^254 square-and-multiply then affine map
// path: six registered round stages, then the affine output stage; while the
// output is stalled, its byte is held and the stages behind it fill up
// throughput: one byte per cycle when not stalled, one item per stage register
// reset: rst_n asynchronous active low clears every stage valid bit
module aes_sbox_forward
    import asf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata   // [7:0] sub_byte
);

    asf_stage_t data  [ROUNDS+1];
    logic       valid [ROUNDS+1];
    logic       ready [ROUNDS+1];

    assign data[0].r     = s_axis_tdata;
    assign data[0].x     = s_axis_tdata;
    assign valid[0]      = s_axis_tvalid;
    assign s_axis_tready = ready[0];

    for (genvar k = 0; k < ROUNDS; k++)
    begin : g_round
        asf_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid[k]),
            .in_ready  (ready[k]),
            .in_data   (data[k]),
            .out_valid (valid[k+1]),
            .out_ready (ready[k+1]),
            .out_data  (data[k+1])
        );
    end

    asf_affine u_affine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid[ROUNDS]),
        .in_ready  (ready[ROUNDS]),
        .in_data   (data[ROUNDS]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata)
    );

endmodule

FILE: hw/rtl/asf_checker.sv
// port-level checks for the aes s-box pipeline, bound to the top level
`include "aes_sbox_forward_defines.svh"

module asf_checker
    import asf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    logic [LATENCY-1:0] zero_hist_reg;
    logic [LATENCY-1:0] rdy_hist_reg;
    logic               zero_xfer;
    logic               zero_due;

    assign zero_xfer = s_axis_tvalid && s_axis_tready && (s_axis_tdata == 8'h00);
    assign zero_due  = zero_hist_reg[LATENCY-1] && (&rdy_hist_reg[LATENCY-2:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_hist_reg <= '0;
            rdy_hist_reg  <= '0;
        end
        else
        begin
            zero_hist_reg <= {zero_hist_reg[LATENCY-2:0], zero_xfer};
            rdy_hist_reg  <= {rdy_hist_reg[LATENCY-2:0], m_axis_tready};
        end
    end

    `ASF_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled output changed")
    `ASF_ASSERT_NOW(a_empty_ready, !m_axis_tvalid, s_axis_tready, "input blocked with empty output")
    `ASF_ASSERT_NOW(a_zero_latency, zero_due, m_axis_tvalid && (m_axis_tdata == AFFINE_CONST), "zero byte result wrong or late")

endmodule

bind aes_sbox_forward asf_checker u_asf_checker (.*);

FILE: bench/tb_aes_sbox_forward.sv
// self-checking testbench for the aes forward s-box stream block
`timescale 1ns / 100ps

module tb_aes_sbox_forward;

    import asf_pkg::LATENCY;

    localparam logic [8:0] FIELD_POLY   = 9'h11b;
    localparam logic [7:0] SBOX_OFFSET  = 8'h63;
    localparam int         MAX_WAIT     = 17;
    localparam int         RANDOM_ITEMS = 1600;
    localparam int         RUN_LIMIT_NS = 5_000_000;

    typedef struct {
        logic [7:0] in_byte;
        int         gap;
        bit         drain;
    } byte_item_t;

    typedef struct {
        logic [7:0] in_byte;
        logic [7:0] sub_byte;
    } sub_expect_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] sub_byte

    byte_item_t  pending_bytes[$];
    sub_expect_t expected_subs[$];
    int          gap_left = 0;
    int          stall_left = 0;
    int          results_seen = 0;
    bit          sink_calm = 1'b0;
    bit          in_taken = 1'b0;
    bit          out_taken = 1'b0;
    int          error_count = 0;

    aes_sbox_forward dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // carry-less product, then fold the high half back modulo the field polynomial
    function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
        logic [15:0] wide;
        wide = 16'h0000;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                wide = wide ^ (16'(a) << i);
            end
        end
        for (int i = 15; i >= 8; i--)
        begin
            if (wide[i])
            begin
                wide = wide ^ (16'(FIELD_POLY) << (i - 8));
            end
        end
        return wide[7:0];
    endfunction

    // zero has no inverse and stays zero
    function automatic logic [7:0] gf_reciprocal(input logic [7:0] a);
        logic [7:0] found;
        found = 8'h00;
        for (int c = 1; c < 256; c++)
        begin
            if (gf_product(a, 8'(c)) == 8'h01)
            begin
                found = 8'(c);
            end
        end
        return found;
    endfunction

    function automatic logic [7:0] sbox_of(input logic [7:0] in_byte);
        logic [7:0] inv;
        logic [7:0] sub;
        inv = gf_reciprocal(in_byte);
        for (int i = 0; i < 8; i++)
        begin
            sub[i] = inv[i] ^ inv[(i + 4) % 8] ^ inv[(i + 5) % 8] ^ inv[(i + 6) % 8]
                     ^ inv[(i + 7) % 8] ^ SBOX_OFFSET[i];
        end
        return sub;
    endfunction

    function automatic byte_item_t make_byte(input logic [7:0] value, input int gap,
                                             input bit drain);
        byte_item_t item;
        item.in_byte = value;
        item.gap     = gap;
        item.drain   = drain;
        return item;
    endfunction

    // input transfers become expectations, output transfers are checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken  <= s_axis_tvalid && s_axis_tready;
            out_taken <= m_axis_tvalid && m_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_subs.push_back('{in_byte: s_axis_tdata,
                                          sub_byte: sbox_of(s_axis_tdata)});
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_subs.size() == 0)
                begin
                    $display("%0t: unexpected sub_byte: expected none, got %02h",
                             $time, m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    if (m_axis_tdata !== expected_subs[0].sub_byte)
                    begin
                        $display("%0t: sub_byte for in_byte %02h: expected %02h, got %02h",
                                 $time, expected_subs[0].in_byte,
                                 expected_subs[0].sub_byte, m_axis_tdata);
                        error_count++;
                    end
                    void'(expected_subs.pop_front());
                end
            end
        end
        else
        begin
            in_taken  <= 1'b0;
            out_taken <= 1'b0;
        end
    end

    // source side
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            if (gap_left > 0)
            begin
                s_axis_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_bytes.size() == 0)
            begin
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_bytes[0].drain && expected_subs.size() != 0)
            begin
                s_axis_tvalid <= 1'b0;
            end
            else
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_bytes[0].in_byte;
                gap_left <= (pending_bytes.size() > 1) ? pending_bytes[1].gap : 0;
                void'(pending_bytes.pop_front());
            end
        end
    end

    // sink side, stalls drawn per result with calm stretches between
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
            begin
                results_seen++;
                if (results_seen % 64 == 0)
                begin
                    sink_calm = ($urandom_range(0, 3) == 0);
                end
                stall_left = sink_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left = stall_left - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        logic [7:0] corner_bytes [20];
        int mode;
        int gap;

        corner_bytes = '{8'h00, 8'h01, 8'hff, 8'h80, 8'h7f, 8'h02, 8'h03,
                         8'h53, 8'hca, 8'h55, 8'haa, 8'h0f, 8'hf0, 8'h8d,
                         8'h10, 8'h63, 8'h40, 8'h20, 8'h04, 8'h08};

        // corner bytes back to back, then the first five again with random gaps
        foreach (corner_bytes[i])
        begin
            pending_bytes.push_back(make_byte(corner_bytes[i], 0, 1'b0));
        end
        for (int i = 0; i < 5; i++)
        begin
            pending_bytes.push_back(make_byte(corner_bytes[i], $urandom_range(0, MAX_WAIT),
                                              1'b0));
        end

        mode = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 100 == 0)
            begin
                mode = $urandom_range(0, 2);
            end
            case (mode)
                0: gap = 0;
                1: gap = $urandom_range(0, MAX_WAIT);
                default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_WAIT) : 0;
            endcase
            pending_bytes.push_back(make_byte(8'($urandom_range(0, 255)), gap,
                                              i == 0 || i == RANDOM_ITEMS / 2));
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || s_axis_tvalid)
        begin
            @(posedge clk);
        end
        while (expected_subs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4 * LATENCY) @(posedge clk);

        if (error_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("%0t: timed out with %0d results outstanding", $time, expected_subs.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
